@@ rtl/gpfa_pkg.sv @@
// Shared types and constants for the pairwise gravity force accumulator.
package gpfa_pkg;

  localparam int DEFAULT_PARTICLE_COUNT = 1024;
  localparam logic [31:0] GRAV_RESET = 32'h0100_0000;

  // Command codes
  localparam logic CMD_INTERACT = 1'b0;
  localparam logic CMD_CLEAR    = 1'b1;

  // Stream widths
  localparam int IN_TDATA_W  = 280;
  localparam int OUT_TDATA_W = 160;
  localparam int INDEX_W     = 10;
  localparam int FORCE_W     = 48;

  // Iterative unit lengths
  localparam int SQRT_STEPS = 35;
  localparam int DIV_STEPS  = 47;

  localparam logic [46:0] MAG_MAX = {47{1'b1}};
  localparam logic signed [47:0] FORCE_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] FORCE_MIN = 48'sh8000_0000_0000;

  // Classified request handed from front to back
  typedef struct packed {
    logic                clear;
    logic                skip;
    logic [INDEX_W-1:0]  i1;
    logic [INDEX_W-1:0]  i2;
    logic [2:0][32:0]    mag;
    logic [2:0]          pos;
    logic [31:0]         grav;
    logic [31:0]         m1;
    logic [31:0]         m2;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_req_t;

endpackage

@@ rtl/gpfa_front.sv @@
// Front end: accepts requests, holds the G register, classifies and forms separations.
module gpfa_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // first_index, second_index, first_x/y/z, second_x/y/z, first_mass, second_mass
  input  logic [gpfa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // command
  input  logic                             s_axis_tuser,
  input  logic                             cfg_we,
  input  logic [31:0]                      cfg_wdata,
  input  logic                             init_done,
  input  logic                             q_full,
  output gpfa_pkg::job_req_t               push
);
  import gpfa_pkg::*;

  logic [31:0] grav_constant;
  logic [2:0][31:0] p1, p2;
  logic [2:0][32:0] sep;
  logic [2:0] nz;
  job_t job;

  // G register
  always_ff @(posedge clk) begin
    if (rst) begin
      grav_constant <= GRAV_RESET;
    end else if (cfg_we) begin
      grav_constant <= cfg_wdata;
    end
  end

  assign s_axis_tready = init_done && !q_full;

  assign p1[0] = s_axis_tdata[51:20];
  assign p1[1] = s_axis_tdata[83:52];
  assign p1[2] = s_axis_tdata[115:84];
  assign p2[0] = s_axis_tdata[147:116];
  assign p2[1] = s_axis_tdata[179:148];
  assign p2[2] = s_axis_tdata[211:180];

  // separation per axis, magnitude and sign
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sep[a] = {p1[a][31], p1[a]} - {p2[a][31], p2[a]};
      nz[a]  = |sep[a];
      job.mag[a] = sep[a][32] ? (33'd0 - sep[a]) : sep[a];
      job.pos[a] = !sep[a][32] && nz[a];
    end
    job.clear = (s_axis_tuser == CMD_CLEAR);
    job.i1    = s_axis_tdata[9:0];
    job.i2    = s_axis_tdata[19:10];
    job.skip  = (job.i1 == job.i2) || (nz == 3'b000);
    job.grav  = grav_constant;
    job.m1    = s_axis_tdata[243:212];
    job.m2    = s_axis_tdata[275:244];
  end

  assign push.valid = s_axis_tvalid && s_axis_tready;
  assign push.job   = job;

endmodule

@@ rtl/gpfa_queue.sv @@
// Two-entry request queue between front and back.
module gpfa_queue (
  input  logic                clk,
  input  logic                rst,
  input  gpfa_pkg::job_req_t  push,
  input  logic                pop,
  output logic                full,
  output gpfa_pkg::job_req_t  head
);
  import gpfa_pkg::*;

  job_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head.valid = (count != 2'd0);
  assign head.job   = entry[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entry[wr_ptr] <= push.job;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push.valid) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      case ({push.valid, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/gpfa_div.sv @@
// One divider lane: 47-bit quotient of a 128-bit numerator, with overflow clip.
module gpfa_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] num,
  input  logic [99:0]  den,
  output logic         done,
  output logic [46:0]  mag,
  output logic         clip
);
  import gpfa_pkg::*;

  logic [99:0]  rem;
  logic [46:0]  nlo;
  logic [46:0]  quo;
  logic [5:0]   cnt;
  logic         run;
  logic [100:0] rem_sh;
  logic         ge;

  assign rem_sh = {rem, nlo[46]};
  assign ge     = (rem_sh >= {1'b0, den});
  assign mag    = clip ? MAG_MAX : quo;

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == 6'(DIV_STEPS - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      clip <= ({19'd0, num[127:47]} >= den);
      rem  <= {19'd0, num[127:47]};
      nlo  <= num[46:0];
      cnt  <= 6'd0;
    end else if (run) begin
      rem  <= ge ? 100'(rem_sh - {1'b0, den}) : rem_sh[99:0];
      quo  <= {quo[45:0], ge};
      nlo  <= {nlo[45:0], 1'b0};
      cnt  <= cnt + 6'd1;
    end
  end

endmodule

@@ rtl/gpfa_back.sv @@
// Back end: force arithmetic, accumulator memory and result register.
module gpfa_back #(
  parameter int PARTICLE_COUNT = gpfa_pkg::DEFAULT_PARTICLE_COUNT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  gpfa_pkg::job_req_t               head,
  output logic                             pop,
  output logic                             init_done,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // particle_index, total_force_x, total_force_y, total_force_z
  output logic [gpfa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // saturated
  output logic                             m_axis_tuser,
  output logic                             m_axis_tlast
);
  import gpfa_pkg::*;

  localparam int ADDR_W = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;

  localparam logic [3:0] ST_INIT = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_CLR  = 4'd2;
  localparam logic [3:0] ST_MUL  = 4'd3;
  localparam logic [3:0] ST_SQRT = 4'd4;
  localparam logic [3:0] ST_DIVS = 4'd5;
  localparam logic [3:0] ST_DIV  = 4'd6;
  localparam logic [3:0] ST_RD   = 4'd7;
  localparam logic [3:0] ST_UPD  = 4'd8;

  // multiplier passes
  localparam logic [3:0] OP_SQX  = 4'd0;
  localparam logic [3:0] OP_SQY  = 4'd1;
  localparam logic [3:0] OP_SQZ  = 4'd2;
  localparam logic [3:0] OP_GM   = 4'd3;
  localparam logic [3:0] OP_GMM  = 4'd4;
  localparam logic [3:0] OP_DEN  = 4'd5;
  localparam logic [3:0] OP_NUMX = 4'd6;
  localparam logic [3:0] OP_NUMY = 4'd7;
  localparam logic [3:0] OP_NUMZ = 4'd8;

  logic [3:0] state;
  job_t       job;
  logic       part;

  // accumulator memory: x, y, z packed per entry
  logic [3*FORCE_W-1:0] mem [PARTICLE_COUNT];
  logic [3*FORCE_W-1:0] rd_data;
  logic [ADDR_W-1:0]    init_cnt;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [3*FORCE_W-1:0] mem_wdata;
  logic                 rd_en;

  // shared multiplier
  logic [3:0]   op;
  logic [1:0]   mcnt;
  logic [1:0]   pshift;
  logic [65:0]  prod;
  logic [127:0] acc;
  logic [127:0] acc_add;
  logic [95:0]  mul_a;
  logic [33:0]  mul_b;
  logic [31:0]  chunk;

  // intermediate values
  logic [65:0]  d2;
  logic [63:0]  gm;
  logic [95:0]  gmm;
  logic [99:0]  den;
  logic [2:0][127:0] num;

  // square root
  logic [69:0]  rad;
  logic [36:0]  srem;
  logic [34:0]  root;
  logic [5:0]   scnt;
  logic [38:0]  srem_sh;
  logic [38:0]  trial;

  // divider lanes
  logic         div_start;
  logic [2:0]   div_done;
  logic [2:0][46:0] div_mag;
  logic [2:0]   div_clip;

  logic signed [2:0][47:0] delta;
  logic         clip;

  // current particle
  logic [9:0]   cur_idx;
  logic [31:0]  cur_idx32;
  logic         in_range;
  logic [ADDR_W-1:0] cur_addr;
  logic         out_free;
  logic signed [2:0][47:0] total;
  logic [2:0]   clamp;

  // result register
  logic [9:0]   out_idx;
  logic [2:0][47:0] out_force;
  logic         out_sat;
  logic         out_last;

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign cur_idx   = part ? job.i2 : job.i1;
  assign cur_idx32 = {22'd0, cur_idx};
  assign in_range  = (cur_idx32 < 32'(PARTICLE_COUNT));
  assign cur_addr  = cur_idx32[ADDR_W-1:0];
  assign pop       = (state == ST_IDLE) && head.valid;
  assign rd_en     = (state == ST_RD) && in_range;

  // memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= mem[cur_addr];
    end
  end

  // new totals with saturation
  always_comb begin
    logic signed [48:0] s;
    for (int a = 0; a < 3; a++) begin
      s = {rd_data[a*FORCE_W+47], rd_data[a*FORCE_W +: FORCE_W]}
          + (part ? -{delta[a][47], delta[a]} : {delta[a][47], delta[a]});
      clamp[a] = (s[48] != s[47]);
      if (!clamp[a]) total[a] = s[47:0];
      else if (s[48]) total[a] = FORCE_MIN;
      else total[a] = FORCE_MAX;
    end
  end

  // memory write select
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = '0;
    unique case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_cnt;
      end
      ST_CLR: begin
        mem_we = out_free && in_range;
      end
      ST_UPD: begin
        mem_we    = out_free && in_range;
        mem_wdata = {total[2], total[1], total[0]};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op) inside
      OP_SQX, OP_SQY, OP_SQZ: begin
        mul_a = {63'd0, job.mag[op[1:0]]};
        mul_b = {1'b0, job.mag[op[1:0]]};
      end
      OP_GM: begin
        mul_a = {64'd0, job.grav};
        mul_b = {2'd0, job.m1};
      end
      OP_GMM: begin
        mul_a = {32'd0, gm};
        mul_b = {2'd0, job.m2};
      end
      OP_DEN: begin
        mul_a = {30'd0, d2};
        mul_b = root[33:0];
      end
      OP_NUMX: begin
        mul_a = gmm;
        mul_b = {1'b0, job.mag[0]};
      end
      OP_NUMY: begin
        mul_a = gmm;
        mul_b = {1'b0, job.mag[1]};
      end
      OP_NUMZ: begin
        mul_a = gmm;
        mul_b = {1'b0, job.mag[2]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    case (mcnt)
      2'd0:    chunk = mul_a[31:0];
      2'd1:    chunk = mul_a[63:32];
      2'd2:    chunk = mul_a[95:64];
      default: chunk = '0;
    endcase
  end

  assign acc_add = acc + (128'(prod) << {pshift, 5'd0});

  // square root step
  assign srem_sh = {srem, rad[69:68]};
  assign trial   = {2'd0, root, 2'b01};

  // divider lanes
  for (genvar g = 0; g < 3; g++) begin : g_lane
    gpfa_div u_div (
      .clk   (clk),
      .rst   (rst),
      .start (div_start),
      .num   (num[g]),
      .den   (den),
      .done  (div_done[g]),
      .mag   (div_mag[g]),
      .clip  (div_clip[g])
    );
  end

  assign div_start = (state == ST_DIVS);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_INIT;
      init_cnt      <= '0;
      init_done     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        ST_INIT: begin
          init_cnt <= init_cnt + 1'b1;
          if (init_cnt == ADDR_W'(PARTICLE_COUNT - 1)) begin
            init_done <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (head.valid) begin
            if (head.job.clear) state <= ST_CLR;
            else if (head.job.skip) state <= ST_RD;
            else state <= ST_MUL;
          end
        end
        ST_CLR: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        ST_MUL: begin
          if (mcnt == 2'd3) begin
            if (op == OP_GMM) state <= ST_SQRT;
            else if (op == OP_NUMZ) state <= ST_DIVS;
          end
        end
        ST_SQRT: begin
          if (scnt == 6'(SQRT_STEPS - 1)) state <= ST_MUL;
        end
        ST_DIVS: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done[0]) state <= ST_RD;
        end
        ST_RD: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            state         <= part ? ST_IDLE : ST_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        job   <= head.job;
        part  <= 1'b0;
        op    <= OP_SQX;
        mcnt  <= 2'd0;
        delta <= '0;
        clip  <= 1'b0;
      end
      ST_CLR: begin
        if (out_free) begin
          out_idx   <= job.i1;
          out_force <= '0;
          out_sat   <= 1'b0;
          out_last  <= 1'b1;
        end
      end
      ST_MUL: begin
        prod   <= {34'd0, chunk} * {32'd0, mul_b};
        pshift <= mcnt;
        mcnt   <= mcnt + 2'd1;
        if (mcnt == 2'd0) begin
          if (op != OP_SQY && op != OP_SQZ) acc <= '0;
        end else begin
          acc <= acc_add;
        end
        if (mcnt == 2'd3) begin
          case (op)
            OP_SQZ:  d2  <= acc_add[65:0];
            OP_GM:   gm  <= acc_add[63:0];
            OP_GMM:  gmm <= acc_add[95:0];
            OP_DEN:  den <= acc_add[99:0];
            OP_NUMX: num[0] <= acc_add;
            OP_NUMY: num[1] <= acc_add;
            OP_NUMZ: num[2] <= acc_add;
            default: ;
          endcase
          op <= op + 4'd1;
          if (op == OP_GMM) begin
            rad  <= {4'd0, d2};
            srem <= '0;
            root <= '0;
            scnt <= '0;
          end
        end
      end
      ST_SQRT: begin
        rad  <= {rad[67:0], 2'b00};
        scnt <= scnt + 6'd1;
        if (srem_sh >= trial) begin
          srem <= 37'(srem_sh - trial);
          root <= {root[33:0], 1'b1};
        end else begin
          srem <= srem_sh[36:0];
          root <= {root[33:0], 1'b0};
        end
      end
      ST_DIV: begin
        if (div_done[0]) begin
          clip <= |div_clip;
          for (int a = 0; a < 3; a++) begin
            delta[a] <= job.pos[a] ? -$signed({1'b0, div_mag[a]})
                                   : $signed({1'b0, div_mag[a]});
          end
        end
      end
      ST_UPD: begin
        if (out_free) begin
          out_idx  <= cur_idx;
          out_last <= part;
          part     <= 1'b1;
          if (in_range) begin
            out_force <= total;
            out_sat   <= clip || (|clamp);
          end else begin
            out_force <= '0;
            out_sat   <= 1'b0;
          end
        end
      end
      default: begin
        part <= part;
      end
    endcase
  end

  assign m_axis_tdata = {6'd0, out_force[2], out_force[1], out_force[0], out_idx};
  assign m_axis_tuser = out_sat;
  assign m_axis_tlast = out_last;

  // checks
  a_no_pop_in_init: assert property (@(posedge clk) disable iff (rst)
    !init_done |-> !pop)
    else $error("request taken before clearing pass ended");

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    div_done[0] |-> (div_done[1] && div_done[2]))
    else $error("divider lanes out of step");

  a_no_write_in_math: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL || state == ST_SQRT || state == ST_DIV) |-> !mem_we)
    else $error("memory written during force computation");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped while stalled");

endmodule

@@ rtl/gravity_pair_force_accumulator_core.sv @@
// Top level of the pairwise gravity force accumulator.
// Interact requests go through nine passes of the shared 32x34 multiplier, a square
// root and three divider lanes that run side by side, then a read-modify-write of each
// particle's entry in the accumulator memory. Same-index or zero-distance pairs skip
// straight to the read-modify-write. A two-entry queue lets new requests enter while one
// is in work. After reset a clearing pass zeroes the memory, during which no request is
// taken; G may be written at any time the block is idle.
module gravity_pair_force_accumulator_core #(
  parameter int PARTICLE_COUNT = gpfa_pkg::DEFAULT_PARTICLE_COUNT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // first_index, second_index, first_x/y/z, second_x/y/z, first_mass, second_mass
  input  logic [gpfa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // command
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // particle_index, total_force_x, total_force_y, total_force_z
  output logic [gpfa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // saturated
  output logic                             m_axis_tuser,
  output logic                             m_axis_tlast,
  input  logic                             cfg_we,
  input  logic [31:0]                      cfg_wdata
);
  import gpfa_pkg::*;

  job_req_t push;
  job_req_t head;
  logic     q_full;
  logic     pop;
  logic     init_done;

  gpfa_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .init_done     (init_done),
    .q_full        (q_full),
    .push          (push)
  );

  gpfa_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (q_full),
    .head (head)
  );

  gpfa_back #(
    .PARTICLE_COUNT (PARTICLE_COUNT)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .init_done     (init_done),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
